### sv/ntia_pkg.sv
`default_nettype none
package ntia_pkg;

    localparam int TABLE_DEPTH = 32;

    localparam int COORD_W = 13;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 24;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int D2_W    = SQ_W + 1;
    localparam int RAD_W   = 58;
    localparam int ROOT_W  = RAD_W / 2;

    localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(15 * 16);
    localparam logic [SQ_W-1:0]    D2_LIMIT     = SQ_W'((500 * 16) * (500 * 16));
    localparam logic [31:0]        SCALE_SQ     = 32'd3906250000;
    localparam logic [SPEED_W-1:0] SPEED_MAX    = '1;

    localparam logic CMD_ASSOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              start;
        logic [RAD_W-1:0]  radicand;
        logic [TIME_W-1:0] divisor;
    } sqdiv_req_t;

endpackage
`default_nettype wire

### sv/ntia_ram.sv
`default_nettype none
module ntia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### sv/ntia_sqdiv.sv
`default_nettype none
module ntia_sqdiv (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ntia_pkg::sqdiv_req_t          req,
    output logic                               done,
    output logic [ntia_pkg::SPEED_W-1:0]       quotient
);
    import ntia_pkg::*;

    typedef enum logic [2:0] {
        SD_IDLE = 3'b001,
        SD_SQRT = 3'b010,
        SD_DIV  = 3'b100
    } sd_state_t;

    sd_state_t           state_reg, state_next;
    logic [4:0]          step_reg, step_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [31:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [TIME_W-1:0]   dvs_reg, dvs_next;
    logic                done_reg, done_next;

    logic [31:0] sq_sh;
    logic [31:0] sq_t;
    logic        sq_ge;
    logic [32:0] dv_sh;
    logic [32:0] dv_diff;
    logic        dv_ge;

    assign sq_sh   = {rem_reg[29:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_t    = {1'b0, root_reg, 2'b01};
    assign sq_ge   = sq_sh >= sq_t;
    assign dv_sh   = {rem_reg, root_reg[ROOT_W-1]};
    assign dv_diff = dv_sh - {1'b0, dvs_reg};
    assign dv_ge   = dv_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dvs_next   = dvs_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            SD_IDLE:
            begin
                if (req.start)
                begin
                    rad_next   = req.radicand;
                    dvs_next   = req.divisor;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = 5'(ROOT_W - 1);
                    state_next = SD_SQRT;
                end
            end
            SD_SQRT:
            begin
                rem_next  = sq_ge ? (sq_sh - sq_t) : sq_sh;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    rem_next   = '0;
                    step_next  = 5'(ROOT_W - 1);
                    state_next = SD_DIV;
                end
            end
            SD_DIV:
            begin
                rem_next  = dv_ge ? dv_diff[31:0] : dv_sh[31:0];
                root_next = {root_reg[ROOT_W-2:0], dv_ge};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    done_next  = 1'b1;
                    state_next = SD_IDLE;
                end
            end
            default:
            begin
                state_next = SD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (|root_reg[ROOT_W-1:SPEED_W]) ? SPEED_MAX : root_reg[SPEED_W-1:0];
endmodule
`default_nettype wire

### sv/nearest_track_id_association.sv
// Nearest track association for cluster centroids.
// Input channel (in_valid/in_stall) carries cmd, x_pos, y_pos and timestamp.
// An associate command scans the valid table entries in order, picks the
// nearest one, and either reuses its ID (reporting speed) or issues a new ID.
// A clear command empties the table and returns an all-zero result.
// Output channel (out_valid/out_stall) carries one result per transfer.
// The configuration channel (cfg_valid/cfg_ready) writes match_radius.
// The scan runs each valid entry through the shared 13x13 multiplier; a
// bit-serial square root and divide follow when a speed is computed, and
// the entries behind the match are moved one place toward the head. The
// table holds 32 entries by default.
// The block takes one item at a time; in_stall is high while it works.
// After reset the table is empty, the ID counter is zero and the radius is
// 240. When the receiver stalls, the result is held in the output register
// and a finished next result waits until that transfer completes.
`default_nettype none
module nearest_track_id_association_unit #(
    parameter int DEPTH = ntia_pkg::TABLE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [ntia_pkg::COORD_W-1:0]  x_pos,
    input  wire logic [ntia_pkg::COORD_W-1:0]  y_pos,
    input  wire logic [ntia_pkg::TIME_W-1:0]   timestamp,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ntia_pkg::ID_W-1:0]          assigned_id,
    output logic                               matched,
    output logic [ntia_pkg::SPEED_W-1:0]       speed,
    output logic                               time_error,
    output logic                               table_full,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ntia_pkg::COORD_W-1:0]  match_radius
);
    import ntia_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SRD  = 13'b0000000000010,
        S_SDIF = 13'b0000000000100,
        S_SQX  = 13'b0000000001000,
        S_SQY  = 13'b0000000010000,
        S_RAD  = 13'b0000000100000,
        S_BRD  = 13'b0000001000000,
        S_BDAT = 13'b0000010000000,
        S_SQST = 13'b0000100000000,
        S_CALC = 13'b0001000000000,
        S_MVRD = 13'b0010000000000,
        S_MVWR = 13'b0100000000000,
        S_TAIL = 13'b1000000000000
    } state_t;

    state_t               state_reg, state_next;
    logic                 done_pend_reg, done_pend_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        best_reg, best_next;
    logic                 found_reg, found_next;
    logic [SQ_W-1:0]      best_d2_reg, best_d2_next;
    logic [SQ_W-1:0]      acc_reg, acc_next;
    logic [SQ_W-1:0]      rad_sq_reg, rad_sq_next;
    logic [COORD_W-1:0]   dx_reg, dx_next;
    logic [COORD_W-1:0]   dy_reg, dy_next;
    logic [COORD_W-1:0]   x_reg, x_next;
    logic [COORD_W-1:0]   y_reg, y_next;
    logic [TIME_W-1:0]    ts_reg, ts_next;
    logic [RAD_W-1:0]     prod_reg, prod_next;
    logic [ID_W-1:0]      id_cnt_reg, id_cnt_next;
    logic [COORD_W-1:0]   radius_reg, radius_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic                 res_match_reg, res_match_next;
    logic [SPEED_W-1:0]   res_speed_reg, res_speed_next;
    logic                 res_terr_reg, res_terr_next;
    logic                 res_full_reg, res_full_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_match_reg, out_match_next;
    logic [SPEED_W-1:0]   out_speed_reg, out_speed_next;
    logic                 out_terr_reg, out_terr_next;
    logic                 out_full_reg, out_full_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    entry_t               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata_raw;
    entry_t               ram_rdata;

    logic [COORD_W-1:0]   mul_a;
    logic [SQ_W-1:0]      mul_p;
    logic [D2_W-1:0]      d2_sum;
    logic [CW-1:0]        idx_dec;
    logic [CW-1:0]        count_dec;
    logic                 out_free;
    sqdiv_req_t           sd_req;
    logic                 sd_done;
    logic [SPEED_W-1:0]   sd_quot;

    assign ram_rdata = entry_t'(ram_rdata_raw);
    assign idx_dec   = idx_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        mul_a = dx_reg;
        if (state_reg == S_SQY)
        begin
            mul_a = dy_reg;
        end
        else if (state_reg == S_RAD)
        begin
            mul_a = radius_reg;
        end
    end

    assign mul_p  = mul_a * mul_a;
    assign d2_sum = {1'b0, acc_reg} + {1'b0, mul_p};

    ntia_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign sd_req.start    = (state_reg == S_SQST);
    assign sd_req.radicand = prod_reg;
    assign sd_req.divisor  = ts_reg - ram_rdata.stamp;

    ntia_sqdiv u_sqdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (sd_req),
        .done     (sd_done),
        .quotient (sd_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        done_pend_next = done_pend_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        best_d2_next   = best_d2_reg;
        acc_next       = acc_reg;
        rad_sq_next    = rad_sq_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ts_next        = ts_reg;
        prod_next      = prod_reg;
        id_cnt_next    = id_cnt_reg;
        radius_next    = radius_reg;
        res_id_next    = res_id_reg;
        res_match_next = res_match_reg;
        res_speed_next = res_speed_reg;
        res_terr_next  = res_terr_reg;
        res_full_next  = res_full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_id_next    = out_id_reg;
        out_match_next = out_match_reg;
        out_speed_next = out_speed_reg;
        out_terr_next  = out_terr_reg;
        out_full_next  = out_full_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = '{ident: res_id_reg, col: x_reg, row: y_reg, stamp: ts_reg};
        ram_raddr      = idx_reg[AW-1:0];

        if (cfg_valid)
        begin
            radius_next = match_radius;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (done_pend_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = res_id_reg;
                        out_match_next = res_match_reg;
                        out_speed_next = res_speed_reg;
                        out_terr_next  = res_terr_reg;
                        out_full_next  = res_full_reg;
                        done_pend_next = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    x_next         = x_pos;
                    y_next         = y_pos;
                    ts_next        = timestamp;
                    res_id_next    = '0;
                    res_match_next = 1'b0;
                    res_speed_next = '0;
                    res_terr_next  = 1'b0;
                    res_full_next  = 1'b0;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    best_d2_next   = D2_LIMIT;
                    if (cmd == CMD_CLEAR)
                    begin
                        count_next     = '0;
                        done_pend_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_SDIF;
                end
                else
                begin
                    state_next = S_RAD;
                end
            end
            S_SDIF:
            begin
                dx_next    = (ram_rdata.col > x_reg) ? ram_rdata.col - x_reg
                                                     : x_reg - ram_rdata.col;
                dy_next    = (ram_rdata.row > y_reg) ? ram_rdata.row - y_reg
                                                     : y_reg - ram_rdata.row;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                acc_next   = mul_p;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                if (d2_sum < {1'b0, best_d2_reg})
                begin
                    best_d2_next = d2_sum[SQ_W-1:0];
                    best_next    = idx_reg[AW-1:0];
                    found_next   = 1'b1;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_SRD;
            end
            S_RAD:
            begin
                rad_sq_next = mul_p;
                state_next  = S_BRD;
            end
            S_BRD:
            begin
                ram_raddr = best_reg;
                if (found_reg && best_d2_reg <= rad_sq_reg)
                begin
                    res_match_next = 1'b1;
                    state_next     = S_BDAT;
                end
                else
                begin
                    id_cnt_next = id_cnt_reg + ID_W'(1);
                    res_id_next = id_cnt_next;
                    if (count_reg < CW'(DEPTH))
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.ident = id_cnt_next;
                        count_next     = count_reg + CW'(1);
                    end
                    else
                    begin
                        res_full_next = 1'b1;
                    end
                    done_pend_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_BDAT:
            begin
                ram_raddr   = best_reg;
                res_id_next = ram_rdata.ident;
                prod_next   = RAD_W'(best_d2_reg) * RAD_W'(SCALE_SQ);
                idx_next    = CW'(best_reg) + CW'(1);
                if (ts_reg > ram_rdata.stamp)
                begin
                    state_next = S_SQST;
                end
                else
                begin
                    res_terr_next = 1'b1;
                    state_next    = S_MVRD;
                end
            end
            S_SQST:
            begin
                ram_raddr  = best_reg;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                ram_raddr = best_reg;
                if (sd_done)
                begin
                    res_speed_next = sd_quot;
                    state_next     = S_MVRD;
                end
            end
            S_MVRD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_MVWR;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_MVWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_dec[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + CW'(1);
                state_next = S_MVRD;
            end
            S_TAIL:
            begin
                ram_we         = 1'b1;
                ram_waddr      = count_dec[AW-1:0];
                done_pend_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_pend_reg <= 1'b0;
            count_reg     <= '0;
            id_cnt_reg    <= '0;
            radius_reg    <= RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_pend_reg <= done_pend_next;
            count_reg     <= count_next;
            id_cnt_reg    <= id_cnt_next;
            radius_reg    <= radius_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        best_reg      <= best_next;
        found_reg     <= found_next;
        best_d2_reg   <= best_d2_next;
        acc_reg       <= acc_next;
        rad_sq_reg    <= rad_sq_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        ts_reg        <= ts_next;
        prod_reg      <= prod_next;
        res_id_reg    <= res_id_next;
        res_match_reg <= res_match_next;
        res_speed_reg <= res_speed_next;
        res_terr_reg  <= res_terr_next;
        res_full_reg  <= res_full_next;
        out_id_reg    <= out_id_next;
        out_match_reg <= out_match_next;
        out_speed_reg <= out_speed_next;
        out_terr_reg  <= out_terr_next;
        out_full_reg  <= out_full_next;
    end

    assign in_stall    = (state_reg != S_IDLE) || done_pend_reg;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign assigned_id = out_id_reg;
    assign matched     = out_match_reg;
    assign speed       = out_speed_reg;
    assign time_error  = out_terr_reg;
    assign table_full  = out_full_reg;
endmodule
`default_nettype wire

### sv/ntia_checker.sv
`default_nettype none
module ntia_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [ntia_pkg::ID_W-1:0]     assigned_id,
    input wire logic                          matched,
    input wire logic [ntia_pkg::SPEED_W-1:0]  speed,
    input wire logic                          time_error,
    input wire logic                          table_full
);
    import ntia_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output transfer dropped while stalled.");

    a_hold_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(assigned_id))
        else $error("Stalled assigned_id changed.");

    a_unmatched_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> speed == '0 && !time_error)
        else $error("Unmatched result reports speed or time error.");

    a_terr_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_error |-> matched && speed == '0)
        else $error("Time error without a zero-speed match.");

    a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !matched && assigned_id != '0)
        else $error("Full-table result reuses a track.");
endmodule

bind nearest_track_id_association_unit ntia_checker u_ntia_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .assigned_id (assigned_id),
    .matched     (matched),
    .speed       (speed),
    .time_error  (time_error),
    .table_full  (table_full)
);
`default_nettype wire
